FILE: design/unique_grid_point_sampler_defines.svh
// Assertion macros shared by the unique grid point sampler RTL.
// Included by every module that carries concurrent checks; no other dependencies.
// With SYNTH defined, the macros expand to nothing.
`ifndef UNIQUE_GRID_POINT_SAMPLER_DEFINES_SVH
`define UNIQUE_GRID_POINT_SAMPLER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define UGPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unique_grid_point_sampler: check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define UGPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unique_grid_point_sampler: check failed");
`else
`define UGPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UGPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/ugps_pkg.sv
// Shared types and constants for the unique grid point sampler.
// Used by the divider, the controller, the datapath, the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package ugps_pkg;

    localparam int RND_W       = 31;  // random value width
    localparam int AREA_W      = 7;   // area width/length register width
    localparam int OFF_W       = 10;  // offset register width
    localparam int COORD_W     = 11;  // output coordinate width
    localparam int IDX_OUT_W   = 12;  // output draw index width
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int EPOCH_W     = 8;   // set tag stored beside each table entry
    localparam int STEP_W      = 5;   // divider step counter width
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [AREA_W-1:0] AREA_RST = AREA_W'(66);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_AREA_WIDTH  = 2'd0,
        CFG_AREA_LENGTH = 2'd1,
        CFG_X_OFFSET    = 2'd2,
        CFG_Y_OFFSET    = 2'd3
    } t_cfg_reg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take an input beat, apply restart, latch cell count
        logic clear;       // write one table entry of the clearing sweep
        logic div1_start;  // start random mod (cells - i)
        logic take_j;      // latch j = i + remainder
        logic rd_j;        // read address is j, else i
        logic cap_a;       // capture table value at i
        logic cap_b;       // capture table value at j
        logic wr_i;        // write b at i, also starts the split of b
        logic wr_j;        // write a at j
        logic out_load;    // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic epoch_full;  // set tag at its top value; next restart needs a sweep
        logic clr_last;    // sweep is at its last entry
        logic exhausted;   // draws in this set reached the cell count
        logic div_busy;
        logic out_full;    // output register holds a beat that is not taken now
    } t_dp_sts;

endpackage

FILE: design/ugps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ugps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ugps_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, step count set at start.
// Depends on ugps_pkg for the dividend width.
`timescale 1ns / 1ps

module ugps_div #(
    parameter int DIV_W = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ugps_pkg::RND_W-1:0]   i_dividend,  // MSB-aligned
    input  logic [DIV_W-1:0]             i_divisor,
    input  logic [ugps_pkg::STEP_W-1:0]  i_steps,
    output logic [ugps_pkg::RND_W-1:0]   o_quot,
    output logic [DIV_W-1:0]             o_rem,
    output logic                         o_busy
);

    import ugps_pkg::*;

    logic [RND_W-1:0]  r_q;
    logic [DIV_W-1:0]  r_r;
    logic [DIV_W-1:0]  r_d;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              q_bit;

    always_comb begin
        trial = {r_r, r_q[RND_W-1]};
        diff  = trial - {1'b0, r_d};
        q_bit = (trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == STEP_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_d   <= i_divisor;
            r_cnt <= i_steps;
        end else if (r_busy) begin
            r_q   <= {r_q[RND_W-2:0], q_bit};
            r_r   <= q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r;
    assign o_busy = r_busy;

endmodule

FILE: design/ugps_dp.sv
// Datapath: configuration registers, set state, lazy permutation table and output beat.
// Depends on ugps_pkg, ugps_ram, ugps_div and the assertion macro header.
`timescale 1ns / 1ps
`include "unique_grid_point_sampler_defines.svh"

module ugps_dp #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ugps_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ugps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [ugps_pkg::RND_W-1:0]         i_rnd,
    input  logic                               i_restart,
    input  ugps_pkg::t_dp_cmd                  i_cmd,
    output ugps_pkg::t_dp_sts                  o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [ugps_pkg::COORD_W-1:0]       o_x,
    output logic [ugps_pkg::COORD_W-1:0]       o_y,
    output logic [ugps_pkg::IDX_OUT_W-1:0]     o_idx,
    output logic                               o_exh
);

    import ugps_pkg::*;

    localparam int IW   = $clog2(MAX_CELLS);        // table index width
    localparam int CW   = $clog2(MAX_CELLS + 1);    // cell count width
    localparam int DW   = (CW > AREA_W) ? CW : AREA_W;
    localparam int MW   = IW + EPOCH_W;             // table word: tag and value

    // Configuration.
    logic [AREA_W-1:0]  r_area_w, r_area_l;
    logic [OFF_W-1:0]   r_x_off, r_y_off;

    // Set state and per-draw operands.
    logic [CW-1:0]      r_drawn;
    logic [EPOCH_W-1:0] r_epoch;
    logic [IW-1:0]      r_clr_addr;
    logic [CW-1:0]      r_cells;
    logic [AREA_W-1:0]  r_iw;
    logic [RND_W-1:0]   r_rnd;
    logic [IW-1:0]      r_j, r_a, r_b, r_rd_addr;

    // Output beat.
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic               r_out_exh;

    logic [AREA_W-1:0]   iw_c, il_c;
    logic [2*AREA_W-1:0] prod_c;
    logic [CW-1:0]       cells_c;
    logic [IW-1:0]       drawn_idx;
    logic                epoch_full;
    logic                clr_last;
    logic                exhausted;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr, mem_raddr;
    logic [MW-1:0]       mem_wdata, mem_rdata;
    logic [IW-1:0]       rd_val;

    logic                div_start, div_busy;
    logic [RND_W-1:0]    div_dividend, div_quot;
    logic [DW-1:0]       div_divisor, div_rem;
    logic [STEP_W-1:0]   div_steps;

    // Inner sizes and the saturated cell count from the current registers.
    always_comb begin
        iw_c   = (r_area_w >= AREA_W'(3)) ? r_area_w - AREA_W'(2) : '0;
        il_c   = (r_area_l >= AREA_W'(3)) ? r_area_l - AREA_W'(2) : '0;
        prod_c = (2*AREA_W)'(iw_c) * (2*AREA_W)'(il_c);
        if (int'(prod_c) > MAX_CELLS) begin
            cells_c = CW'(MAX_CELLS);
        end else begin
            cells_c = CW'(prod_c);
        end
    end

    assign drawn_idx  = r_drawn[IW-1:0];
    assign epoch_full = (r_epoch == '1);
    assign clr_last   = (r_clr_addr == IW'(MAX_CELLS - 1));
    assign exhausted  = (r_drawn >= r_cells);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_w <= AREA_RST;
            r_area_l <= AREA_RST;
            r_x_off  <= '0;
            r_y_off  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_AREA_WIDTH:  r_area_w <= i_cfg_data[AREA_W-1:0];
                CFG_AREA_LENGTH: r_area_l <= i_cfg_data[AREA_W-1:0];
                CFG_X_OFFSET:    r_x_off  <= i_cfg_data[OFF_W-1:0];
                CFG_Y_OFFSET:    r_y_off  <= i_cfg_data[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Draw count, set tag and sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawn    <= '0;
            r_epoch    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.load && i_restart) begin
                r_drawn <= '0;
                if (!epoch_full) begin
                    r_epoch <= r_epoch + EPOCH_W'(1);
                end
            end else if (i_cmd.out_load && !exhausted) begin
                r_drawn <= r_drawn + CW'(1);
            end
            if (i_cmd.clear) begin
                if (clr_last) begin
                    r_clr_addr <= '0;
                    r_epoch    <= EPOCH_W'(1);
                end else begin
                    r_clr_addr <= r_clr_addr + IW'(1);
                end
            end
        end
    end

    // An entry whose tag differs from the current set reads as its own index.
    assign rd_val = (mem_rdata[IW +: EPOCH_W] == r_epoch) ? mem_rdata[IW-1:0] : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rnd   <= i_rnd;
            r_iw    <= iw_c;
            r_cells <= cells_c;
        end
        if (i_cmd.take_j) begin
            r_j <= drawn_idx + div_rem[IW-1:0];
        end
        if (i_cmd.cap_a) begin
            r_a <= rd_val;
        end
        if (i_cmd.cap_b) begin
            r_b <= rd_val;
        end
        r_rd_addr <= mem_raddr;
    end

    always_comb begin
        mem_raddr = i_cmd.rd_j ? r_j : drawn_idx;
        mem_we    = i_cmd.clear || i_cmd.wr_i || i_cmd.wr_j;
        if (i_cmd.clear) begin
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.wr_i) begin
            mem_waddr = drawn_idx;
            mem_wdata = {r_epoch, r_b};
        end else begin
            mem_waddr = r_j;
            mem_wdata = {r_epoch, r_a};
        end
    end

    ugps_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_CELLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The first division reduces the random value, the second splits b by the inner width.
    always_comb begin
        div_start = i_cmd.div1_start || i_cmd.wr_i;
        if (i_cmd.wr_i) begin
            div_dividend = RND_W'(r_b) << (RND_W - IW);
            div_divisor  = DW'(r_iw);
            div_steps    = STEP_W'(IW);
        end else begin
            div_dividend = r_rnd;
            div_divisor  = DW'(r_cells - r_drawn);
            div_steps    = STEP_W'(RND_W);
        end
    end

    ugps_div #(
        .DIV_W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_busy     (div_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (exhausted) begin
                r_out_x   <= '0;
                r_out_y   <= '0;
                r_out_idx <= '0;
                r_out_exh <= 1'b1;
            end else begin
                r_out_x   <= COORD_W'(div_rem[AREA_W-1:0]) + COORD_W'(r_x_off);
                r_out_y   <= div_quot[COORD_W-1:0] + COORD_W'(r_y_off);
                r_out_idx <= IDX_OUT_W'(r_drawn);
                r_out_exh <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.epoch_full = epoch_full;
        o_sts.clr_last   = clr_last;
        o_sts.exhausted  = exhausted;
        o_sts.div_busy   = div_busy;
        o_sts.out_full   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_x         = r_out_x;
    assign o_y         = r_out_y;
    assign o_idx       = r_out_idx;
    assign o_exh       = r_out_exh;

    // The swap partner always lies inside the current cell range.
    `UGPS_ASSERT_IMP(a_j_in_range, i_clk, i_rst_n, i_cmd.wr_j, CW'(r_j) < r_cells)
    // Tag zero marks swept entries; it is never the tag of a live set.
    `UGPS_ASSERT_IMP(a_epoch_live, i_clk, i_rst_n, i_cmd.out_load, r_epoch != '0)

endmodule

FILE: design/ugps_ctrl.sv
// Controller state machine: sequences the sweep, the divisions and the table swap.
// Depends on ugps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "unique_grid_point_sampler_defines.svh"

module ugps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_restart,
    output logic              o_in_ready,
    output ugps_pkg::t_dp_cmd o_cmd,
    input  ugps_pkg::t_dp_sts i_sts
);

    import ugps_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DIV1,
        S_RD_I,
        S_RD_J,
        S_CAP_B,
        S_WR_I,
        S_WR_J,
        S_DIV2,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_resume, n_resume;
    logic   accept;
    logic   sweep_req;

    assign accept    = (r_state == S_IDLE) && i_in_valid;
    assign sweep_req = accept && i_restart && i_sts.epoch_full;

    always_comb begin
        n_state  = r_state;
        n_resume = r_resume;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_resume ? S_CHECK : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (sweep_req) begin
                        n_state  = S_CLEAR;
                        n_resume = 1'b1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.exhausted) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div1_start = 1'b1;
                    n_state          = S_DIV1;
                end
            end
            S_DIV1: begin
                if (!i_sts.div_busy) begin
                    n_state = S_RD_I;
                end
            end
            S_RD_I: begin
                o_cmd.take_j = 1'b1;
                n_state      = S_RD_J;
            end
            S_RD_J: begin
                o_cmd.rd_j  = 1'b1;
                o_cmd.cap_a = 1'b1;
                n_state     = S_CAP_B;
            end
            S_CAP_B: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_WR_I;
            end
            S_WR_I: begin
                o_cmd.wr_i = 1'b1;
                n_state    = S_WR_J;
            end
            S_WR_J: begin
                o_cmd.wr_j = 1'b1;
                n_state    = S_DIV2;
            end
            S_DIV2: begin
                if (!i_sts.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_resume <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // A restart with the set tag at its top value must sweep the table first.
    `UGPS_ASSERT_NXT(a_restart_sweep, i_clk, i_rst_n, sweep_req, r_state == S_CLEAR)
    // The divider reports busy in the cycle after it is started.
    `UGPS_ASSERT_NXT(a_div_runs, i_clk, i_rst_n, o_cmd.div1_start, i_sts.div_busy)

endmodule

FILE: design/unique_grid_point_sampler.sv
// Unique grid point sampler: draws interior grid cells without repetition by a
// partial Fisher-Yates shuffle over a lazily kept permutation table held in RAM.
// Each input beat carries one random value and a restart flag and yields exactly
// one output beat. In a normal draw a 31-step serial divider reduces the random
// value modulo the cells left, two table reads and two table writes perform the
// swap, the same divider then splits the chosen index into column and row in
// log2(MAX_CELLS) steps, and the result is loaded into the output register as the
// controller returns to idle, where the next beat can be taken. A draw on an
// exhausted set skips the divisions and the swap. A result that finds the output
// register still occupied waits there until that beat is taken. After reset, and on
// every 255th restart, the table is swept once over all MAX_CELLS entries while no
// input beat is taken; configuration writes are accepted at all times but must only
// be issued while the block is idle.
// Depends on ugps_pkg, ugps_ctrl and ugps_dp.
`timescale 1ns / 1ps

module unique_grid_point_sampler #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Configuration: area_width, area_length, x_offset, y_offset at index 0 to 3.
    input  logic                                 i_cfg_we,
    input  logic [ugps_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [ugps_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    // Input beats.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ugps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [30:0] random_value
    input  logic                                 s_axis_tuser,  // [0] restart

    // Output beats.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ugps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [10:0] x_coord,
                                                                // [21:11] y_coord,
                                                                // [33:22] draw_index
    output logic                                 m_axis_tuser   // [0] exhausted
);

    import ugps_pkg::*;

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [COORD_W-1:0]   out_x, out_y;
    logic [IDX_OUT_W-1:0] out_idx;

    // The controller only sequences; all state of the set lives in the datapath.
    ugps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_restart  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // The output register in the datapath lets a new beat be taken while the
    // previous result still waits on the output side.
    ugps_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_rnd       (s_axis_tdata[RND_W-1:0]),
        .i_restart   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_x         (out_x),
        .o_y         (out_y),
        .o_idx       (out_idx),
        .o_exh       (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_idx, out_y, out_x});

endmodule

FILE: verif/unique_grid_point_sampler_test.sv
// Self-checking testbench for the unique grid point sampler: a scoreboard class keeps its own
// lazily marked shuffle table and predicts every output beat. Depends on ugps_pkg and the RTL.
`timescale 1ns / 1ps

module unique_grid_point_sampler_test;

    import ugps_pkg::*;

    localparam int TABLE_CELLS = 4096;
    localparam int ITEM_TARGET = 1100;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 600;
    localparam int MAX_PRINTS  = 40;

    // One expected output beat.
    typedef struct {
        bit [COORD_W-1:0]   x;
        bit [COORD_W-1:0]   y;
        bit [IDX_OUT_W-1:0] draw_no;
        bit                 exhausted;
    } t_grid_point;

    // The scoreboard holds a private copy of the registers and of the permutation table.
    // Every accepted input beat is replayed on that copy and queues the point it must produce.
    class draw_scoreboard;
        bit [AREA_W-1:0]      area_w;
        bit [AREA_W-1:0]      area_l;
        bit [OFF_W-1:0]       off_x;
        bit [OFF_W-1:0]       off_y;
        bit [IDX_OUT_W-1:0]   perm [TABLE_CELLS];
        bit                   marked [TABLE_CELLS];
        int unsigned          drawn;
        t_grid_point          expected_q[$];
        int unsigned          mismatches;
        int unsigned          points;
        int unsigned          exhausted_seen;
        int unsigned          restarts;

        function new();
            area_w = AREA_RST;
            area_l = AREA_RST;
            off_x  = '0;
            off_y  = '0;
            drawn  = 0;
        endfunction

        function int unsigned inner(bit [AREA_W-1:0] outer);
            return (outer >= 3) ? outer - 2 : 0;
        endfunction

        // The interior cell count, saturated at the table size.
        function int unsigned cell_count();
            int unsigned cells;
            cells = inner(area_w) * inner(area_l);
            return (cells > TABLE_CELLS) ? TABLE_CELLS : cells;
        endfunction

        function void set_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] d);
            case (r)
                CFG_AREA_WIDTH:  area_w = d[AREA_W-1:0];
                CFG_AREA_LENGTH: area_l = d[AREA_W-1:0];
                CFG_X_OFFSET:    off_x  = d[OFF_W-1:0];
                CFG_Y_OFFSET:    off_y  = d[OFF_W-1:0];
                default: ;
            endcase
        endfunction

        // One shuffle step: swap entry i with a random entry at or above it.
        function void note_draw(bit [RND_W-1:0] rnd, bit restart);
            int unsigned         iw;
            int unsigned         cells;
            int unsigned         i;
            int unsigned         j;
            bit [IDX_OUT_W-1:0]  a;
            bit [IDX_OUT_W-1:0]  b;
            t_grid_point         p;
            iw    = inner(area_w);
            cells = cell_count();
            if (restart) begin
                marked = '{default: 1'b0};
                drawn  = 0;
                restarts++;
            end
            i = drawn;
            p = '{x: '0, y: '0, draw_no: '0, exhausted: 1'b0};
            if (i >= cells || iw == 0) begin
                // Every interior cell is already out: nothing changes.
                p.exhausted = 1'b1;
            end else begin
                j = i + rnd % (cells - i);
                // An entry that was never written stands for its own index.
                a = marked[i] ? perm[i] : IDX_OUT_W'(i);
                b = marked[j] ? perm[j] : IDX_OUT_W'(j);
                perm[i]   = b;
                marked[i] = 1'b1;
                perm[j]   = a;
                marked[j] = 1'b1;
                drawn     = i + 1;
                // Entries left over from a larger area can exceed the grid, so the sums wrap.
                p.x       = COORD_W'(b % iw + off_x);
                p.y       = COORD_W'(b / iw + off_y);
                p.draw_no = IDX_OUT_W'(i);
            end
            expected_q.push_back(p);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            if (mismatches < MAX_PRINTS) begin
                $display("[%0t] output beat %0d: %s is %0d, expected %0d",
                         $time, points, what, got, want);
            end
            mismatches++;
        endtask

        task check_point(bit [COORD_W-1:0] x, bit [COORD_W-1:0] y,
                         bit [IDX_OUT_W-1:0] draw_no, bit exhausted);
            t_grid_point want;
            if (expected_q.size() == 0) begin
                report_mismatch("beat with nothing pending, draw_no", draw_no, 0);
            end else begin
                want = expected_q.pop_front();
                if (x != want.x)                 report_mismatch("x_coord", x, want.x);
                if (y != want.y)                 report_mismatch("y_coord", y, want.y);
                if (draw_no != want.draw_no)     report_mismatch("draw_index", draw_no, want.draw_no);
                if (exhausted != want.exhausted) report_mismatch("exhausted", exhausted, want.exhausted);
                if (want.exhausted) exhausted_seen++;
            end
            points++;
        endtask
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;  // [30:0] random_value
    logic                    s_axis_tuser  = 1'b0; // [0] restart
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // [10:0] x_coord, [21:11] y_coord,
                                                  // [33:22] draw_index
    logic                    m_axis_tuser;        // [0] exhausted

    draw_scoreboard sb = new();

    // Idling controls for the sender and the receiver, and run counters.
    bit          no_gaps     = 1'b0;
    bit          hold_start  = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned hold_seen   = 0;
    int unsigned items_sent  = 0;
    int unsigned settings    = 0;

    unique_grid_point_sampler #(
        .MAX_CELLS (TABLE_CELLS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog. The slowest legal run is well under a tenth of this.
    initial begin
        #20_000_000;
        $display("unique_grid_point_sampler_test: errors");
        $finish;
    end

    // Both handshakes are sampled at the rising edge, before anything driven at that edge
    // lands, so the input beat is always noted before an output beat of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_draw(s_axis_tdata[RND_W-1:0], s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_point(m_axis_tdata[10:0], m_axis_tdata[21:11], m_axis_tdata[33:22],
                               m_axis_tuser);
            end
        end
    end

    // The receiver. A hold-off request keeps tready low for a long stretch so that the
    // output register fills and the block stops taking input beats.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_start && hold_left == 0) begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                hold_seen++;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one input beat, with random idle cycles ahead of it, and return at the edge
    // where it is taken.
    task automatic send_draw(input bit [RND_W-1:0] rnd, input bit restart);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, rnd};
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering beats and wait for every pending point. An exhausted draw skips the
    // divisions and the swap, so a short pause afterwards leaves the block idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Write all four registers back to back. The area registers get junk above bit 6,
    // which the block must ignore.
    task automatic write_regs(input bit [AREA_W-1:0] w, input bit [AREA_W-1:0] l,
                              input bit [OFF_W-1:0] xo, input bit [OFF_W-1:0] yo);
        t_cfg_reg               regs [4];
        logic [CFG_DATA_W-1:0]  vals [4];
        regs = '{CFG_AREA_WIDTH, CFG_AREA_LENGTH, CFG_X_OFFSET, CFG_Y_OFFSET};
        vals = '{{3'($urandom), w}, {3'($urandom), l}, xo, yo};
        for (int n = 0; n < 4; n++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= regs[n];
            i_cfg_data <= vals[n];
            sb.set_reg(regs[n], vals[n]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        bit [AREA_W-1:0]  w;
        bit [AREA_W-1:0]  l;
        bit [OFF_W-1:0]   xo;
        bit [OFF_W-1:0]   yo;
        bit [RND_W-1:0]   rnd;
        bit               restart;
        bit               keep_set;
        int unsigned      phase_no;
        int unsigned      kind;
        int unsigned      cells_now;
        int unsigned      sets;
        int unsigned      set_len;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default 66 by 66 area: the full table, extreme and alternating random values.
        // The first beat also waits out the clearing sweep after reset.
        send_draw(31'h0000_0000, 1'b1);
        send_draw(31'h7FFF_FFFF, 1'b0);
        send_draw(31'h5555_5555, 1'b0);
        send_draw(31'h2AAA_AAAA, 1'b0);
        send_draw(31'h0000_0000, 1'b0);
        send_draw(31'h7FFF_FFFF, 1'b1);
        settle();

        // A single interior cell with both offsets at their top: one point, then exhausted,
        // and a restart after exhaustion.
        write_regs(7'd3, 7'd3, 10'd1023, 10'd1023);
        send_draw(31'd7, 1'b1);
        send_draw(31'h7FFF_FFFF, 1'b0);
        send_draw(31'd0, 1'b0);
        send_draw(31'd5, 1'b1);
        settle();

        // Degenerate areas: a width or a length below three leaves no interior.
        write_regs(7'd2, 7'd127, 10'd0, 10'd0);
        send_draw(31'd0, 1'b1);
        send_draw(31'd9, 1'b0);
        settle();
        write_regs(7'd127, 7'd0, 10'd0, 10'd0);
        send_draw(31'd1, 1'b1);
        settle();

        // The widest area saturates the cell count at the table size.
        write_regs(7'd127, 7'd127, 10'd1023, 10'd0);
        send_draw(31'h7FFF_FFFF, 1'b1);
        send_draw(31'd0, 1'b0);
        send_draw(31'd123456, 1'b0);
        settle();

        // Two cells, drawn out and then one exhausted answer.
        write_regs(7'd4, 7'd3, 10'd0, 10'd1023);
        send_draw(31'd1, 1'b1);
        send_draw(31'd1, 1'b0);
        send_draw(31'd0, 1'b0);
        settle();

        // Grow the area inside the same set: the draw carries on from where it stopped.
        write_regs(7'd3, 7'd127, 10'd0, 10'd0);
        send_draw(31'h7FFF_FFFF, 1'b0);
        send_draw(31'h1234_5678, 1'b0);

        // Random part. Each setting mostly runs well-formed sets (a restart, then draws up to
        // and past exhaustion for small areas), with stray restarts as noise. Some settings
        // keep the set that was open before the registers changed.
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            phase_no++;
            kind = $urandom_range(9);
            case (kind)
                0: begin
                    w = AREA_W'($urandom_range(0, 2));
                    l = AREA_W'($urandom_range(0, 127));
                end
                1: begin
                    w = AREA_W'($urandom_range(3, 127));
                    l = AREA_W'($urandom_range(0, 2));
                end
                2: begin
                    w = AREA_W'($urandom_range(20, 127));
                    l = AREA_W'($urandom_range(20, 127));
                end
                3: begin
                    w = $urandom_range(1) ? 7'd127 : 7'd3;
                    l = $urandom_range(1) ? 7'd127 : 7'd3;
                end
                default: begin
                    w = AREA_W'($urandom_range(3, 9));
                    l = AREA_W'($urandom_range(3, 9));
                end
            endcase
            case ($urandom_range(3))
                0:       xo = '0;
                1:       xo = '1;
                default: xo = OFF_W'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(3))
                0:       yo = '0;
                1:       yo = '1;
                default: yo = OFF_W'($urandom_range(0, 1023));
            endcase

            settle();
            write_regs(w, l, xo, yo);
            if (phase_no == 3) hold_start = 1'b1;
            no_gaps = (phase_no == 6 || phase_no == 7);

            keep_set  = ($urandom_range(4) == 0);
            cells_now = sb.cell_count();
            // The hold-off setting runs the most sets so that beats keep coming while the
            // output side is blocked.
            sets      = (phase_no == 3) ? 5 : $urandom_range(2, 5);
            for (int s = 0; s < sets; s++) begin
                if (cells_now == 0) begin
                    set_len = $urandom_range(1, 3);
                end else if (cells_now <= 40) begin
                    set_len = cells_now + $urandom_range(0, 3);
                end else begin
                    set_len = $urandom_range(5, 40);
                end
                for (int k = 0; k < set_len; k++) begin
                    restart = (k == 0 && !(s == 0 && keep_set)) || ($urandom_range(24) == 0);
                    case ($urandom_range(15))
                        0:       rnd = '0;
                        1:       rnd = '1;
                        default: rnd = RND_W'($urandom());
                    endcase
                    send_draw(rnd, restart);
                end
            end
        end
        no_gaps = 1'b0;

        settle();
        repeat (52) @(posedge i_clk);

        $display("Run covered %0d draws (%0d points checked, %0d of them exhausted) over %0d",
                 items_sent, sb.points, sb.exhausted_seen, settings);
        $display("register settings, %0d restarts and %0d cycles of output held off.",
                 sb.restarts, hold_seen);
        if (sb.mismatches == 0) begin
            $display("unique_grid_point_sampler_test: clean");
        end else begin
            $display("unique_grid_point_sampler_test: errors");
        end
        $finish;
    end

endmodule

FILE: unique_grid_point_sampler.f
+incdir+design
design/ugps_pkg.sv
design/ugps_ram.sv
design/ugps_div.sv
design/ugps_dp.sv
design/ugps_ctrl.sv
design/unique_grid_point_sampler.sv
verif/unique_grid_point_sampler_test.sv
